// ===== rtl/ech_pkg.sv =====
// Package for the event count histogram: codes, request types and fixed sizes.
`timescale 1ns / 1ps
package ech_pkg;

  localparam int StoreDepth = 307200;
  localparam int IndexW     = 19;
  localparam int CountW     = 32;
  localparam int TimeW      = 64;
  localparam int CoordW     = 16;
  localparam int PosW       = 12;
  localparam int UsPerBin   = 1000;
  localparam int DiffW      = 29;
  localparam int RecipW     = 30;
  localparam int RecipShift = 39;
  localparam logic [RecipW-1:0] Recip = 30'd549755814;
  localparam int QDepth     = 4;
  localparam int QPtrW      = 2;
  localparam int CreditW    = 3;

  localparam logic ModeTime  = 1'b0;
  localparam logic ActRead   = 1'b1;

  typedef enum logic [1:0] {
    OpCount   = 2'd0,
    OpRead    = 2'd1,
    OpReadOob = 2'd2,
    OpDrop    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StsCounted = 2'd0,
    StsDropped = 2'd1,
    StsRead    = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] addr;
  } queue_item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// ===== rtl/ech_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ech_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ech_front.sv =====
// Front end: reference capture, range checks and address computation per request.
`timescale 1ns / 1ps
module ech_front #(
  parameter int SENSOR_WIDTH  = 640,
  parameter int SENSOR_HEIGHT = 480,
  parameter int TIME_BINS     = 10000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        mode_i,
  input  logic                        action_i,
  input  logic [ech_pkg::TimeW-1:0]   event_time_i,
  input  logic [ech_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [ech_pkg::CoordW-1:0]  pixel_y_i,
  input  logic [ech_pkg::IndexW-1:0]  read_index_i,
  output logic                        push_o,
  output ech_pkg::queue_item_t        item_o
);
  import ech_pkg::*;

  localparam int BinLimit = (TIME_BINS < StoreDepth) ? TIME_BINS : StoreDepth;
  localparam logic [TimeW-1:0] TimeLimit = TimeW'(BinLimit) * TimeW'(UsPerBin);
  localparam int TProdW = DiffW + RecipW;
  localparam int PProdW = 2 * PosW + 1;

  logic [TimeW-1:0] ref_q, ref_d;
  logic             ref_valid_q, ref_valid_d;
  logic [TimeW-1:0] ref_eff;
  logic [TimeW:0]   diff_full;

  logic                f1_valid_q;
  logic                f1_read_q, f1_oob_q, f1_mode_q, f1_drop_q;
  logic [TimeW-1:0]    f1_diff_q;
  logic [PosW-1:0]     f1_x_q, f1_y_q;
  logic [IndexW-1:0]   f1_ridx_q;

  logic                f2_valid_q;
  logic                f2_read_q, f2_oob_q, f2_mode_q, f2_drop_q, f2_drop_d;
  logic [TProdW-1:0]   f2_tprod_q, f2_tprod_d;
  logic [PProdW-1:0]   f2_pprod_q, f2_pprod_d;
  logic [PosW-1:0]     f2_y_q;
  logic [IndexW-1:0]   f2_ridx_q;

  logic [PProdW-1:0]   paddr;

  assign ref_eff   = ref_valid_q ? ref_q : event_time_i;
  assign diff_full = {1'b0, event_time_i} - {1'b0, ref_eff};

  always_comb begin
    ref_d       = ref_q;
    ref_valid_d = ref_valid_q;
    if (accept_i && (action_i != ActRead) && (mode_i == ModeTime) && !ref_valid_q) begin
      ref_d       = event_time_i;
      ref_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      ref_valid_q <= 1'b0;
      f1_valid_q  <= 1'b0;
      f2_valid_q  <= 1'b0;
    end else begin
      ref_q       <= ref_d;
      ref_valid_q <= ref_valid_d;
      f1_valid_q  <= accept_i;
      f2_valid_q  <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      f1_read_q <= (action_i == ActRead);
      f1_oob_q  <= (read_index_i >= IndexW'(StoreDepth));
      f1_mode_q <= mode_i;
      f1_drop_q <= (mode_i == ModeTime) ? diff_full[TimeW]
                 : ((pixel_x_i >= CoordW'(SENSOR_WIDTH)) ||
                    (pixel_y_i >= CoordW'(SENSOR_HEIGHT)));
      f1_diff_q <= diff_full[TimeW-1:0];
      f1_x_q    <= pixel_x_i[PosW-1:0];
      f1_y_q    <= pixel_y_i[PosW-1:0];
      f1_ridx_q <= read_index_i;
    end
  end

  always_comb begin
    f2_drop_d  = f1_drop_q || ((f1_mode_q == ModeTime) && (f1_diff_q >= TimeLimit));
    f2_tprod_d = {{RecipW{1'b0}}, f1_diff_q[DiffW-1:0]} * TProdW'(Recip);
    f2_pprod_d = {{(PosW+1){1'b0}}, f1_x_q} * PProdW'(SENSOR_HEIGHT);
  end

  always_ff @(posedge clk_i) begin
    if (f1_valid_q) begin
      f2_read_q  <= f1_read_q;
      f2_oob_q   <= f1_oob_q;
      f2_mode_q  <= f1_mode_q;
      f2_drop_q  <= f2_drop_d;
      f2_tprod_q <= f2_tprod_d;
      f2_pprod_q <= f2_pprod_d;
      f2_y_q     <= f1_y_q;
      f2_ridx_q  <= f1_ridx_q;
    end
  end

  assign paddr = f2_pprod_q + PProdW'(f2_y_q);

  always_comb begin
    item_o.op   = OpDrop;
    item_o.addr = '0;
    if (f2_read_q) begin
      item_o.op   = f2_oob_q ? OpReadOob : OpRead;
      item_o.addr = f2_ridx_q;
    end else if (f2_drop_q) begin
      item_o.op   = OpDrop;
    end else if (f2_mode_q == ModeTime) begin
      item_o.op   = OpCount;
      item_o.addr = f2_tprod_q[RecipShift +: IndexW];
    end else if (paddr < PProdW'(StoreDepth)) begin
      item_o.op   = OpCount;
      item_o.addr = paddr[IndexW-1:0];
    end
  end

  assign push_o = f2_valid_q;

endmodule

// ===== rtl/ech_queue.sv =====
// Short request queue between the front end and the counter back end.
`timescale 1ns / 1ps
module ech_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ech_pkg::queue_item_t item_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ech_pkg::queue_item_t item_o
);
  import ech_pkg::*;

  queue_item_t        slot_q [QDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [CreditW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CreditW'(1);
      2'b01:   count_d = count_q - CreditW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rptr_q];

endmodule

// ===== rtl/ech_back.sv =====
// Back end: counter store clear pass, read-modify-write and result register.
`timescale 1ns / 1ps
module ech_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  ech_pkg::queue_item_t       q_item_i,
  output ech_pkg::back_stat_t        stat_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [ech_pkg::IndexW-1:0] bin_index_o,
  output logic [ech_pkg::CountW-1:0] count_value_o
);
  import ech_pkg::*;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StWait  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IndexW-1:0] clr_q, clr_d;
  queue_item_t       item_q, item_d;

  logic              ram_we, ram_re;
  logic [IndexW-1:0] ram_addr;
  logic [CountW-1:0] ram_wdata, ram_rdata, bumped;

  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [IndexW-1:0] bin_q, bin_d;
  logic [CountW-1:0] count_q, count_d;
  logic              pop;

  ech_ram #(
    .Width (CountW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign bumped = (ram_rdata == '1) ? ram_rdata : ram_rdata + CountW'(1);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    item_d    = item_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = item_q.addr;
    ram_wdata = bumped;
    pop       = 1'b0;
    done_d    = 1'b0;
    status_d  = status_q;
    bin_d     = bin_q;
    count_d   = count_q;
    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + IndexW'(1);
        if (clr_q == IndexW'(StoreDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (q_valid_i) begin
          pop = 1'b1;
          case (q_item_i.op)
            OpDrop: begin
              done_d   = 1'b1;
              status_d = StsDropped;
              bin_d    = '0;
              count_d  = '0;
            end
            OpReadOob: begin
              done_d   = 1'b1;
              status_d = StsRead;
              bin_d    = q_item_i.addr;
              count_d  = '0;
            end
            default: begin
              ram_re   = 1'b1;
              ram_addr = q_item_i.addr;
              item_d   = q_item_i;
              state_d  = StWait;
            end
          endcase
        end
      end
      StWait: begin
        done_d  = 1'b1;
        bin_d   = item_q.addr;
        state_d = StIdle;
        if (item_q.op == OpRead) begin
          status_d = StsRead;
          count_d  = ram_rdata;
        end else begin
          ram_we   = 1'b1;
          status_d = StsCounted;
          count_d  = bumped;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    bin_q    <= bin_d;
    count_q  <= count_d;
  end

  assign stat_o.clearing = (state_q == StClear);
  assign stat_o.pop      = pop;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign bin_index_o     = bin_q;
  assign count_value_o   = count_q;

endmodule

// ===== rtl/event_count_histogram.sv =====
// Top level of the event count histogram accumulator.
//
//   channel   direction  handshake                    payload
//   request   in         start high, busy low         action_i event_time_i pixel_x_i
//                                                     pixel_y_i read_index_i
//   result    out        done_o, one cycle            status_o bin_index_o count_value_o
//   config    in         cfg_we_i                     cfg_wdata_i (count_mode)
//
// A request passes front-end registers f1 and f2, then the queue; the back end ends a drop
// or an out-of-range read in its idle state and a counter read or update in its wait state
// (single RAM port, read then write), taking no new request while it waits for the RAM.
// After reset the counter store is cleared one entry a cycle: busy stays high until all
// 307200 entries are cleared; configuration writes are taken throughout.
// The result side cannot stall; busy rises when four requests are in flight.
`timescale 1ns / 1ps
module event_count_histogram #(
  parameter int SENSOR_WIDTH  = 640,
  parameter int SENSOR_HEIGHT = 480,
  parameter int TIME_BINS     = 10000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        action_i,
  input  logic [ech_pkg::TimeW-1:0]   event_time_i,
  input  logic [ech_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [ech_pkg::CoordW-1:0]  pixel_y_i,
  input  logic [ech_pkg::IndexW-1:0]  read_index_i,
  output logic                        busy,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [ech_pkg::IndexW-1:0]  bin_index_o,
  output logic [ech_pkg::CountW-1:0]  count_value_o
);
  import ech_pkg::*;

  logic               mode_q;
  logic               accept;
  logic [CreditW-1:0] credits_q, credits_d;
  logic               push;
  queue_item_t        push_item, q_item;
  logic               q_valid;
  back_stat_t         back_stat;

  assign busy   = back_stat.clearing || (credits_q == CreditW'(QDepth));
  assign accept = start && !busy;

  always_comb begin
    credits_d = credits_q;
    case ({accept, back_stat.pop})
      2'b10:   credits_d = credits_q + CreditW'(1);
      2'b01:   credits_d = credits_q - CreditW'(1);
      default: credits_d = credits_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeTime;
      credits_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      credits_q <= credits_d;
    end
  end

  ech_front #(
    .SENSOR_WIDTH  (SENSOR_WIDTH),
    .SENSOR_HEIGHT (SENSOR_HEIGHT),
    .TIME_BINS     (TIME_BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_q),
    .action_i     (action_i),
    .event_time_i (event_time_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .read_index_i (read_index_i),
    .push_o       (push),
    .item_o       (push_item)
  );

  ech_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (back_stat.pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ech_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .stat_o        (back_stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .bin_index_o   (bin_index_o),
    .count_value_o (count_value_o)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credits_q <= CreditW'(QDepth))
    else $error("request credits exceed queue depth");

  a_pop_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> (credits_q != '0))
    else $error("queue pop without an outstanding request");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.clearing |-> !done_o)
    else $error("result strobe during store clear");

  a_accept_then_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !back_stat.pop) |=> (credits_q == $past(credits_q) + CreditW'(1)))
    else $error("accepted request not counted");
`endif

endmodule
